// ===== sv/jdc_pkg.sv =====
// ----------------------------------------------------------------------------
// jdc_pkg
// shared types, calendar constants and constant-divisor helpers for the
// julian day / gregorian calendar converter
// ----------------------------------------------------------------------------
package jdc_pkg;

  // opcodes of an input word
  typedef enum logic [1:0] {
    OpFromJd   = 2'd0,
    OpFromYmd  = 2'd1,
    OpFromYdoy = 2'd2
  } op_e;

  // supported span of day numbers: 0001-01-01 .. 9999-12-31
  localparam logic [22:0] SpanLow  = 23'd1721426;
  localparam logic [22:0] SpanHigh = 23'd5373484;

  // calendar constants
  localparam int unsigned YearBias   = 4800;
  localparam int unsigned DayBias    = 32045;
  localparam int unsigned JdOffset   = 32044;
  localparam int unsigned Days400Yr  = 146097;
  localparam int unsigned Days4Yr    = 1461;
  localparam int unsigned Days5Mon   = 153;
  localparam int unsigned JanOfs     = 307;   // first day plus march-based january
  localparam logic [3:0]  MarchJan   = 4'd10; // january in march-based months

  // word handed from the day-number encoder to the decoder
  typedef struct packed {
    logic        bad;
    logic [23:0] jd;
  } jdc_day_t;

  // one result word
  typedef struct packed {
    logic        oos;
    logic [22:0] jd;
    logic [13:0] yr;
    logic [3:0]  mon;
    logic [4:0]  dy;
    logic [2:0]  wd;
    logic [8:0]  ord;
    logic [2:0]  wim;
    logic [5:0]  wiy;
    logic        leap;
  } jdc_res_t;

  // reciprocal constants: for x < 2**W, q = (x * K) >> S with
  // S = W + clog2(D) and K = ceil(2**S / D) is exact
  localparam int unsigned Div100W  = 15;
  localparam int unsigned Div100S  = Div100W + $clog2(100);
  localparam longint unsigned Div100K = ((64'd1 << Div100S) + 64'd99) / 64'd100;

  localparam int unsigned DivEraW  = 25;
  localparam int unsigned DivEraS  = DivEraW + $clog2(Days400Yr);
  localparam longint unsigned DivEraK =
    ((64'd1 << DivEraS) + 64'(Days400Yr) - 64'd1) / 64'(Days400Yr);

  localparam int unsigned Div7W    = 23;
  localparam int unsigned Div7S    = Div7W + $clog2(7);
  localparam longint unsigned Div7K = ((64'd1 << Div7S) + 64'd6) / 64'd7;

  localparam int unsigned DivQuadW = 18;
  localparam int unsigned DivQuadS = DivQuadW + $clog2(Days4Yr);
  localparam longint unsigned DivQuadK =
    ((64'd1 << DivQuadS) + 64'(Days4Yr) - 64'd1) / 64'(Days4Yr);

  localparam int unsigned DivMonW  = 11;
  localparam int unsigned DivMonS  = DivMonW + $clog2(Days5Mon);
  localparam longint unsigned DivMonK =
    ((64'd1 << DivMonS) + 64'(Days5Mon) - 64'd1) / 64'(Days5Mon);

  localparam int unsigned Div7sW   = 9;
  localparam int unsigned Div7sS   = Div7sW + $clog2(7);
  localparam longint unsigned Div7sK = ((64'd1 << Div7sS) + 64'd6) / 64'd7;

  // x / 100 for x below 25600
  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [30:0] p;
    p = 31'(x) * 31'(Div100K);
    return p[Div100S +: 8];
  endfunction

  // x / 146097
  function automatic logic [7:0] div_era(input logic [24:0] x);
    logic [50:0] p;
    p = 51'(x) * 51'(DivEraK);
    return p[DivEraS +: 8];
  endfunction

  // x / 7 for wide x
  function automatic logic [20:0] div7(input logic [22:0] x);
    logic [46:0] p;
    p = 47'(x) * 47'(Div7K);
    return p[Div7S +: 21];
  endfunction

  // x / 1461
  function automatic logic [7:0] div_quad(input logic [17:0] x);
    logic [36:0] p;
    p = 37'(x) * 37'(DivQuadK);
    return p[DivQuadS +: 8];
  endfunction

  // x / 153
  function automatic logic [3:0] div_mon(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'(DivMonK);
    return p[DivMonS +: 4];
  endfunction

  // x / 7 for narrow x
  function automatic logic [6:0] div7s(input logic [8:0] x);
    logic [18:0] p;
    p = 19'(x) * 19'(Div7sK);
    return p[Div7sS +: 7];
  endfunction

  // days before a march-based month: (153 * mm + 2) / 5
  function automatic logic [8:0] month_offset(input logic [3:0] mm);
    logic [8:0] r;
    case (mm)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd398;
      4'd14:   r = 9'd428;
      default: r = 9'd459;
    endcase
    return r;
  endfunction

  // days in the march-based years before yy: 365yy + yy/4 - yy/100 + yy/400
  function automatic logic [23:0] year_days(input logic [14:0] yy, input logic [7:0] q100);
    return 24'(yy) * 24'd365 + 24'(yy[14:2]) - 24'(q100) + 24'(q100[7:2]);
  endfunction

endpackage

// ===== sv/jdc_encode.sv =====
// ----------------------------------------------------------------------------
// jdc_encode
// two-stage pipeline that forms the day number from an input word
// ----------------------------------------------------------------------------
module jdc_encode import jdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [1:0]  opcode_i,
  input  logic [22:0] julian_day_i,
  input  logic [13:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [8:0]  day_of_year_i,
  output logic        valid_o,
  output jdc_day_t    item_o
);

  typedef struct packed {
    logic        from_jd;
    logic        bad;
    logic [22:0] jd_in;
    logic [14:0] yy;
    logic [7:0]  q100;
    logic [9:0]  off;
  } enc_a_t;

  enc_a_t     sa_d, sa_q;
  jdc_day_t   item_d, item_q;
  logic       va_q, vb_q;
  logic [14:0] yy;
  logic [3:0]  mm;
  logic [8:0]  dd;
  logic [23:0] sum;

  // stage a: select march-based year, month and day, divide year by 100
  always_comb begin
    yy           = {1'b0, year_i} + 15'(YearBias);
    mm           = '0;
    dd           = '0;
    sa_d.from_jd = 1'b0;
    sa_d.bad     = 1'b0;
    unique case (opcode_i)
      OpFromJd: begin
        sa_d.from_jd = 1'b1;
      end
      OpFromYmd: begin
        if (month_i <= 4'd2) begin
          yy = {1'b0, year_i} + 15'(YearBias - 1);
          mm = month_i + 4'd9;
        end else begin
          mm = month_i - 4'd3;
        end
        dd = {4'b0, day_i};
      end
      OpFromYdoy: begin
        yy = {1'b0, year_i} + 15'(YearBias - 1);
        mm = MarchJan;
        dd = day_of_year_i;
      end
      default: begin
        sa_d.bad = 1'b1;
      end
    endcase
    sa_d.jd_in = julian_day_i;
    sa_d.yy    = yy;
    sa_d.q100  = div100(yy);
    sa_d.off   = 10'(month_offset(mm)) + 10'(dd);
  end

  // stage b: sum the day number
  always_comb begin
    sum         = year_days(sa_q.yy, sa_q.q100) + 24'(sa_q.off) - 24'(DayBias);
    item_d.bad  = sa_q.bad;
    item_d.jd   = sa_q.from_jd ? {1'b0, sa_q.jd_in} : sum;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    sa_q   <= sa_d;
    item_q <= item_d;
  end

  assign valid_o = vb_q;
  assign item_o  = item_q;

endmodule

// ===== sv/jdc_decode.sv =====
// ----------------------------------------------------------------------------
// jdc_decode
// ten-stage pipeline that splits a day number into date, weekday, ordinal
// day, week numbers and leap flag, and checks it against the span
// ----------------------------------------------------------------------------
module jdc_decode import jdc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  jdc_day_t item_i,
  output logic     valid_o,
  output jdc_res_t res_o
);

  typedef struct packed {
    logic        oos;
    logic [22:0] jd;
    logic [22:0] a;
    logic [7:0]  b;
    logic [20:0] q7;
  } s1_t;

  typedef struct packed {
    logic        oos;
    logic [22:0] jd;
    logic [7:0]  b;
    logic [15:0] c;
    logic [2:0]  wd;
    logic [6:0]  d;
    logic [8:0]  e;
    logic [3:0]  m;
  } s2_t;

  typedef struct packed {
    logic        oos;
    logic [22:0] jd;
    logic [2:0]  wd;
    logic [13:0] yr;
    logic [3:0]  mon;
    logic [4:0]  dy;
    logic [14:0] yy2;
    logic [7:0]  q100f;
    logic [7:0]  q100y;
    logic [5:0]  x;
    logic [22:0] first;
    logic        leap;
    logic [2:0]  fom;
    logic [8:0]  ord;
    logic [20:0] fq7;
    logic [2:0]  wim;
  } s6_t;

  s1_t        s1_d, s1_q;
  s2_t        s2_d, s2_q, s3_d, s3_q, s4_d, s4_q, s5_d, s5_q;
  s6_t        s6_d, s6_q, s7_d, s7_q, s8_d, s8_q, s9_d, s9_q;
  jdc_res_t   s10_d, s10_q;
  logic [10:1] v_q;

  logic [25:0] era_days;
  logic [23:0] wd_rem;
  logic [17:0] quad_days;
  logic [14:0] yr_wide;
  logic [23:0] first_sum;
  logic [13:0] r100;
  logic [6:0]  fom_q;
  logic [6:0]  wim_q;
  logic [6:0]  wiy_q;
  logic [23:0] fw_rem;
  logic [8:0]  wiy_sum;
  logic [2:0]  fw;

  // stage 1: span check, century count and weekday quotient
  always_comb begin
    s1_d.oos = item_i.bad || (item_i.jd < 24'(SpanLow)) || (item_i.jd > 24'(SpanHigh));
    s1_d.jd  = item_i.jd[22:0];
    s1_d.a   = item_i.jd[22:0] + 23'(JdOffset);
    s1_d.b   = div_era({s1_d.a, 2'b11});
    s1_d.q7  = div7(item_i.jd[22:0] + 23'd1);
  end

  // stage 2: day within century and weekday
  always_comb begin
    s2_d     = '0;
    s2_d.oos = s1_q.oos;
    s2_d.jd  = s1_q.jd;
    s2_d.b   = s1_q.b;
    era_days = 26'(s1_q.b) * 26'(Days400Yr);
    s2_d.c   = 16'(24'(s1_q.a) - 24'(era_days[25:2]));
    wd_rem   = 24'(s1_q.jd) + 24'd1 - 24'(s1_q.q7) * 24'd7;
    s2_d.wd  = wd_rem[2:0];
  end

  // stage 3: year within century
  always_comb begin
    s3_d   = s2_q;
    s3_d.d = 7'(div_quad({s2_q.c, 2'b11}));
  end

  // stage 4: day within year
  always_comb begin
    s4_d      = s3_q;
    quad_days = 18'(s3_q.d) * 18'(Days4Yr);
    s4_d.e    = 9'(s3_q.c - quad_days[17:2]);
  end

  // stage 5: march-based month
  always_comb begin
    s5_d   = s4_q;
    s5_d.m = div_mon(11'(s4_q.e) * 11'd5 + 11'd2);
  end

  // stage 6: normalized year, month and day
  always_comb begin
    s6_d     = '0;
    s6_d.oos = s5_q.oos;
    s6_d.jd  = s5_q.jd;
    s6_d.wd  = s5_q.wd;
    s6_d.dy  = 5'(s5_q.e - month_offset(s5_q.m) + 9'd1);
    s6_d.mon = (s5_q.m >= 4'd10) ? s5_q.m - 4'd9 : s5_q.m + 4'd3;
    yr_wide  = 15'(s5_q.b) * 15'd100 + 15'(s5_q.d) + 15'(s5_q.m >= 4'd10)
             - 15'(YearBias);
    s6_d.yr  = yr_wide[13:0];
  end

  // stage 7: century quotients for january first and the leap test, weekday offset of the first of the month
  always_comb begin
    s7_d       = s6_q;
    s7_d.yy2   = {1'b0, s6_q.yr} + 15'(YearBias - 1);
    s7_d.q100f = div100(s7_d.yy2);
    s7_d.q100y = div100({1'b0, s6_q.yr});
    s7_d.x     = 6'd36 + 6'(s6_q.wd) - 6'(s6_q.dy);
  end

  // stage 8: day number of january first, leap flag, weekday of the first of the month
  always_comb begin
    s8_d       = s7_q;
    first_sum  = year_days(s7_q.yy2, s7_q.q100f) + 24'(JanOfs) - 24'(DayBias);
    s8_d.first = first_sum[22:0];
    r100       = s7_q.yr - 14'(s7_q.q100y) * 14'd100;
    s8_d.leap  = (s7_q.yr[1:0] == 2'b00) && ((r100 != 14'd0) || (s7_q.q100y[1:0] == 2'b00));
    fom_q      = div7s(9'(s7_q.x));
    s8_d.fom   = 3'(9'(s7_q.x) - 9'(fom_q) * 9'd7);
  end

  // stage 9: ordinal day, week of month, year weekday quotient
  always_comb begin
    s9_d      = s8_q;
    s9_d.ord  = 9'(s8_q.jd - s8_q.first + 23'd1);
    s9_d.fq7  = div7(s8_q.first + 23'd1);
    wim_q     = div7s(9'(s8_q.dy) - 9'd1 + 9'(s8_q.fom));
    s9_d.wim  = wim_q[2:0] + 3'd1;
  end

  // stage 10: week of year and result word
  always_comb begin
    fw_rem       = 24'(s9_q.first) + 24'd1 - 24'(s9_q.fq7) * 24'd7;
    fw           = fw_rem[2:0];
    wiy_sum      = s9_q.ord - 9'd1 + 9'(fw);
    wiy_q        = div7s(wiy_sum);
    s10_d.oos    = s9_q.oos;
    s10_d.jd     = s9_q.jd;
    s10_d.yr     = s9_q.yr;
    s10_d.mon    = s9_q.mon;
    s10_d.dy     = s9_q.dy;
    s10_d.wd     = s9_q.wd;
    s10_d.ord    = s9_q.ord;
    s10_d.wim    = s9_q.wim;
    s10_d.wiy    = wiy_q[5:0] + 6'd1;
    s10_d.leap   = s9_q.leap;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[9:1], valid_i};
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    s2_q  <= s2_d;
    s3_q  <= s3_d;
    s4_q  <= s4_d;
    s5_q  <= s5_d;
    s6_q  <= s6_d;
    s7_q  <= s7_d;
    s8_q  <= s8_d;
    s9_q  <= s9_d;
    s10_q <= s10_d;
  end

  assign valid_o = v_q[10];
  assign res_o   = s10_q;

endmodule

// ===== sv/julian_day_calendar_converter_top.sv =====
// ----------------------------------------------------------------------------
// julian_day_calendar_converter_top
// converts day numbers, dates and ordinal dates to a full calendar word
// ----------------------------------------------------------------------------
//
// channel   direction  handshake          payload
// command   in         start_i, busy_o    opcode_i, julian_day_i, year_i,
//                                          month_i, day_i, day_of_year_i
// result    out        done_o             out_of_span_o .. leap_o
//
// one word is taken every cycle; busy_o stays low, so start_i is never held off.
// a result reaches the ports through one register per stage of the encoder (2),
// the decoder (10) and the output register (1).
// reset clears the valid bits only; words in flight are dropped.
// done_o is a one-cycle strobe; the receiver cannot stall.
//
module julian_day_calendar_converter_top import jdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [22:0] julian_day_i,
  input  logic [13:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [8:0]  day_of_year_i,
  output logic        done_o,
  output logic        out_of_span_o,
  output logic [22:0] day_number_o,
  output logic [13:0] out_year_o,
  output logic [3:0]  out_month_o,
  output logic [4:0]  out_day_o,
  output logic [2:0]  weekday_o,
  output logic [8:0]  ordinal_day_o,
  output logic [2:0]  week_in_month_o,
  output logic [5:0]  week_in_year_o,
  output logic        leap_o
);

  logic     enc_valid;
  jdc_day_t enc_item;
  logic     dec_valid;
  jdc_res_t dec_res;
  jdc_res_t out_d, out_q;
  logic     done_q;

  assign busy_o = 1'b0;

  // day number forming
  jdc_encode u_encode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start_i & ~busy_o),
    .opcode_i      (opcode_i),
    .julian_day_i  (julian_day_i),
    .year_i        (year_i),
    .month_i       (month_i),
    .day_i         (day_i),
    .day_of_year_i (day_of_year_i),
    .valid_o       (enc_valid),
    .item_o        (enc_item)
  );

  // calendar split
  jdc_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (enc_valid),
    .item_i  (enc_item),
    .valid_o (dec_valid),
    .res_o   (dec_res)
  );

  // an out-of-span word reports the flag alone
  always_comb begin
    if (dec_res.oos) begin
      out_d     = '0;
      out_d.oos = 1'b1;
    end else begin
      out_d = dec_res;
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dec_valid;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o          = done_q;
  assign out_of_span_o   = out_q.oos;
  assign day_number_o    = out_q.jd;
  assign out_year_o      = out_q.yr;
  assign out_month_o     = out_q.mon;
  assign out_day_o       = out_q.dy;
  assign weekday_o       = out_q.wd;
  assign ordinal_day_o   = out_q.ord;
  assign week_in_month_o = out_q.wim;
  assign week_in_year_o  = out_q.wiy;
  assign leap_o          = out_q.leap;

endmodule
